@@ hw/rtl/sscl_pkg.sv @@
// Shared constants, types and command/status structs for the slab size-class lookup.
package sscl_pkg;

    // Table geometry and sizing rules.
    localparam int CLASS_COUNT       = 64;
    localparam int MAX_ITEM_BYTES    = 1048576;
    localparam int FIRST_CHUNK_BYTES = 96;
    localparam int CHUNK_ALIGN       = 8;

    // Field and datapath widths.
    localparam int CLASS_W  = 6;
    localparam int ITEM_W   = 22;
    localparam int CHUNK_W  = 21;
    localparam int FACTOR_W = 19;
    localparam int FRAC_W   = 16;
    localparam int SIZE_W   = 24;
    localparam int PROD_W   = SIZE_W + FACTOR_W;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_GROWTH_FACTOR = 1'b0;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(81920);

    // Build stops once size times factor passes the maximum chunk in Q27.16.
    localparam logic [PROD_W-1:0] PROD_LIMIT = PROD_W'(64'(MAX_ITEM_BYTES) << FRAC_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B_INIT,
        ST_B_MUL,
        ST_B_CHK,
        ST_B_MUL2,
        ST_B_NEXT,
        ST_LK_CMP,
        ST_PUSH
    } sscl_state_t;

    typedef struct packed {
        logic size_init;
        logic prod_load;
        logic size_align;
        logic size_shift;
        logic idx_init;
        logic idx_inc;
        logic tbl_wr;
        logic tbl_wr_max;
        logic last_load;
        logic item_load;
        logic rd_en;
        logic rd_next;
        logic res_hit;
        logic res_miss;
        logic out_load;
    } sscl_cmd_t;

    typedef struct packed {
        logic prod_over;
        logic idx_top;
        logic item_in_zero;
        logic hit;
        logic idx_last;
        logic out_free;
    } sscl_status_t;

endpackage

@@ hw/rtl/slab_size_class_lookup_core.sv @@
// Top level of the slab size-class lookup: config register, controller and datapath.
//
//  Channel   Handshake                     Payload
//  config    psel/penable/pwrite, pready   paddr, pwdata, prdata (growth_factor_q16)
//  input     in_valid / in_ready           item_bytes
//  output    out_valid / out_ready         class_id, chunk_bytes, largest_class
//
// A request of size zero goes straight to the push state; one that ends at class k is
// compared with classes 1 to k in turn through the single read port of the chunk table,
// which the search walks one class a cycle. After reset, and after every factor write once
// the controller has passed through idle, the table is rebuilt: each class through B_MUL,
// B_CHK, B_MUL2 and B_NEXT, the last through B_MUL and B_CHK (the shared size multiplier
// is used twice per class). No request is taken then. A result waits in the output register
// while the next request is accepted; the search holds its result until that register is free.
module slab_size_class_lookup_core import sscl_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ITEM_W-1:0]   item_bytes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CLASS_W-1:0]  class_id,
    output logic [CHUNK_W-1:0]  chunk_bytes,
    output logic [CLASS_W-1:0]  largest_class
);

    logic [FACTOR_W-1:0] factor_reg;
    logic                cfg_wr;
    sscl_cmd_t           cmd;
    sscl_status_t        status;

    // Factor register write decode.
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GROWTH_FACTOR);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GROWTH_FACTOR) ? DATA_W'(factor_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            factor_reg <= FACTOR_RESET;
        else if (cfg_wr)
            factor_reg <= pwdata[FACTOR_W-1:0];
    end

    sscl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .in_valid (in_valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    sscl_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .factor        (factor_reg),
        .item_bytes    (item_bytes),
        .out_ready     (out_ready),
        .status        (status),
        .out_valid     (out_valid),
        .class_id      (class_id),
        .chunk_bytes   (chunk_bytes),
        .largest_class (largest_class)
    );

    // A found class never lies past the last built class and always has a nonzero chunk.
    a_class_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && class_id != '0 |-> class_id <= largest_class && chunk_bytes != '0)
        else $error("class beyond largest class or empty chunk");

    // A failed lookup reports a zero chunk.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && class_id == '0 |-> chunk_bytes == '0)
        else $error("failed lookup with nonzero chunk");

    // A factor write blocks new requests until the rebuild has run.
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !in_ready)
        else $error("request accepted right after factor write");

    // The table always has at least one class.
    a_largest_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> largest_class != '0)
        else $error("largest class is zero");

endmodule

@@ hw/rtl/sscl_dpath.sv @@
// Datapath: size multiplier, chunk table memory, search compare and output register.
module sscl_dpath import sscl_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  sscl_cmd_t           cmd,
    input  logic [FACTOR_W-1:0] factor,
    input  logic [ITEM_W-1:0]   item_bytes,
    input  logic                out_ready,
    output sscl_status_t        status,
    output logic                out_valid,
    output logic [CLASS_W-1:0]  class_id,
    output logic [CHUNK_W-1:0]  chunk_bytes,
    output logic [CLASS_W-1:0]  largest_class
);

    logic [SIZE_W-1:0]  size_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CLASS_W-1:0] idx_reg;
    logic [CLASS_W-1:0] last_reg;
    logic [ITEM_W-1:0]  item_reg;
    logic [CHUNK_W-1:0] rd_data_reg;
    logic [CLASS_W-1:0] res_class_reg;
    logic [CHUNK_W-1:0] res_chunk_reg;
    logic               out_valid_reg;
    logic [CLASS_W-1:0] out_class_reg;
    logic [CHUNK_W-1:0] out_chunk_reg;
    logic [CLASS_W-1:0] out_largest_reg;
    logic [CHUNK_W-1:0] tbl_mem [CLASS_COUNT];

    logic [SIZE_W-1:0]  size_aligned;
    logic [CHUNK_W-1:0] tbl_wdata;
    logic [CLASS_W-1:0] rd_addr;

    // Round the candidate size up to the chunk alignment.
    assign size_aligned = (size_reg + SIZE_W'(CHUNK_ALIGN - 1)) & ~SIZE_W'(CHUNK_ALIGN - 1);
    assign tbl_wdata    = cmd.tbl_wr_max ? CHUNK_W'(MAX_ITEM_BYTES) : size_aligned[CHUNK_W-1:0];
    assign rd_addr      = cmd.rd_next ? idx_reg + CLASS_W'(1) : CLASS_W'(1);

    // Build registers: candidate size, product with the factor, class index; also the request size.
    always_ff @(posedge clk)
    begin
        if (cmd.size_init)
            size_reg <= SIZE_W'(FIRST_CHUNK_BYTES);
        else if (cmd.size_align)
            size_reg <= size_aligned;
        else if (cmd.size_shift)
            size_reg <= prod_reg[FRAC_W +: SIZE_W];

        if (cmd.prod_load)
            prod_reg <= PROD_W'(size_reg) * PROD_W'(factor);

        if (cmd.idx_init)
            idx_reg <= CLASS_W'(1);
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + CLASS_W'(1);

        if (cmd.item_load)
            item_reg <= item_bytes;
    end

    // The last class index survives until the next rebuild.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= CLASS_W'(1);
        else if (cmd.last_load)
            last_reg <= idx_reg;
    end

    // Chunk table: one write port for the build, one registered read port for the search.
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_wr)
            tbl_mem[idx_reg] <= tbl_wdata;
        if (cmd.rd_en)
            rd_data_reg <= tbl_mem[rd_addr];
    end

    // Pending result of the current request.
    always_ff @(posedge clk)
    begin
        if (cmd.res_hit)
        begin
            res_class_reg <= idx_reg;
            res_chunk_reg <= rd_data_reg;
        end
        else if (cmd.res_miss)
        begin
            res_class_reg <= '0;
            res_chunk_reg <= '0;
        end
    end

    // Output register with its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_class_reg   <= res_class_reg;
            out_chunk_reg   <= res_chunk_reg;
            out_largest_reg <= last_reg;
        end
    end

    // Status back to the controller.
    assign status.prod_over    = prod_reg > PROD_LIMIT;
    assign status.idx_top      = idx_reg == CLASS_W'(CLASS_COUNT - 1);
    assign status.item_in_zero = item_bytes == '0;
    assign status.hit          = item_reg <= ITEM_W'(rd_data_reg);
    assign status.idx_last     = idx_reg == last_reg;
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign class_id      = out_class_reg;
    assign chunk_bytes   = out_chunk_reg;
    assign largest_class = out_largest_reg;

endmodule

@@ hw/rtl/sscl_ctrl.sv @@
// Controller: sequences the table build and the class search for each request.
module sscl_ctrl import sscl_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr,
    input  logic         in_valid,
    input  sscl_status_t status,
    output logic         in_ready,
    output sscl_cmd_t    cmd
);

    sscl_state_t state_reg;
    sscl_state_t state_next;
    logic        pend_reg;
    logic        pend_next;

    // State register and pending-rebuild flag; reset starts a build.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_B_INIT;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg | cfg_wr;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pend_reg)
                    state_next = ST_B_INIT;
                else
                begin
                    in_ready = !cfg_wr;
                    if (in_valid && !cfg_wr)
                    begin
                        cmd.item_load = 1'b1;
                        if (status.item_in_zero)
                        begin
                            cmd.res_miss = 1'b1;
                            state_next   = ST_PUSH;
                        end
                        else
                        begin
                            cmd.idx_init = 1'b1;
                            cmd.rd_en    = 1'b1;
                            state_next   = ST_LK_CMP;
                        end
                    end
                end
            end
            ST_B_INIT:
            begin
                pend_next     = cfg_wr;
                cmd.size_init = 1'b1;
                cmd.idx_init  = 1'b1;
                state_next    = ST_B_MUL;
            end
            ST_B_MUL:
            begin
                cmd.prod_load = 1'b1;
                state_next    = ST_B_CHK;
            end
            ST_B_CHK:
            begin
                cmd.tbl_wr = 1'b1;
                if (status.idx_top || status.prod_over)
                begin
                    // Last class holds the maximum chunk.
                    cmd.tbl_wr_max = 1'b1;
                    cmd.last_load  = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.size_align = 1'b1;
                    state_next     = ST_B_MUL2;
                end
            end
            ST_B_MUL2:
            begin
                cmd.prod_load = 1'b1;
                state_next    = ST_B_NEXT;
            end
            ST_B_NEXT:
            begin
                cmd.size_shift = 1'b1;
                cmd.idx_inc    = 1'b1;
                state_next     = ST_B_MUL;
            end
            ST_LK_CMP:
            begin
                if (status.hit)
                begin
                    cmd.res_hit = 1'b1;
                    state_next  = ST_PUSH;
                end
                else if (status.idx_last)
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = ST_PUSH;
                end
                else
                begin
                    // Move on to the next class and read its entry for the next compare.
                    cmd.idx_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                end
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ tb/slab_size_class_lookup_core_test.sv @@
// Self-checking testbench for the slab size-class lookup core.
`timescale 1ns / 100ps

module slab_size_class_lookup_core_test;
    import sscl_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 7;
    localparam int MAX_WAIT       = 18;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 144;
    localparam int SETTLE_CYCLES  = 80;
    localparam int TIMEOUT_CYCLES = 600000;

    localparam logic [ADDR_W-1:0] FACTOR_ADDR = ADDR_W'(4 * REG_GROWTH_FACTOR);
    localparam logic [ADDR_W-1:0] SPARE_ADDR  = ADDR_W'(4);

    localparam int unsigned FACTOR_ONE        = 65536;
    localparam int unsigned FACTOR_HALF       = 32768;
    localparam int unsigned FACTOR_MAX_GROWTH = 262144;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic [CHUNK_W-1:0] chunk;
        logic [CLASS_W-1:0] largest;
    } lookup_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [ITEM_W-1:0]   item_bytes;
    logic                out_valid;
    logic                out_ready;
    logic [CLASS_W-1:0]  class_id;
    logic [CHUNK_W-1:0]  chunk_bytes;
    logic [CLASS_W-1:0]  largest_class;

    // Predicted size-class table and its growth factor.
    logic [FACTOR_W-1:0] model_factor;
    longint unsigned     chunk_table [CLASS_COUNT];
    int unsigned         top_class;

    lookup_result_t      pending_lookups [$];
    lookup_result_t      next_expected;
    int                  errors;
    logic                no_idle;

    slab_size_class_lookup_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .item_bytes    (item_bytes),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .class_id      (class_id),
        .chunk_bytes   (chunk_bytes),
        .largest_class (largest_class)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Rebuild the geometric chunk table for a given Q3.16 factor.
    function automatic void build_class_table(input logic [FACTOR_W-1:0] factor);
        longint unsigned size;
        longint unsigned bound;
        int unsigned     k;
        int              i;
        bound = longint'(MAX_ITEM_BYTES) << FRAC_W;
        size  = FIRST_CHUNK_BYTES;
        k     = 1;
        for (i = 0; i < CLASS_COUNT; i++)
            chunk_table[i] = 0;
        while (k < CLASS_COUNT - 1 && size * factor <= bound)
        begin
            if (size % CHUNK_ALIGN != 0)
                size = size + CHUNK_ALIGN - size % CHUNK_ALIGN;
            chunk_table[k] = size;
            size = (size * factor) >> FRAC_W;
            k++;
        end
        top_class      = k;
        chunk_table[k] = MAX_ITEM_BYTES;
    endfunction

    // Smallest class, in index order, whose chunk holds the item.
    function automatic lookup_result_t lookup_class(input logic [ITEM_W-1:0] bytes);
        lookup_result_t r;
        int unsigned    k;
        logic           found;
        r.class_id = '0;
        r.chunk    = '0;
        r.largest  = CLASS_W'(top_class);
        found      = 1'b0;
        if (bytes != 0)
        begin
            for (k = 1; k <= top_class && k < CLASS_COUNT && !found; k++)
            begin
                if (bytes <= chunk_table[k])
                begin
                    r.class_id = CLASS_W'(k);
                    r.chunk    = CHUNK_W'(chunk_table[k]);
                    found      = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Random request size: often near class boundaries, with corner values and some noise.
    function automatic logic [ITEM_W-1:0] pick_item_bytes();
        int unsigned     pick;
        int unsigned     k;
        longint unsigned base;
        logic [ITEM_W-1:0] v;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            v = ITEM_W'($urandom);
        else if (pick == 1)
        begin
            case ($urandom_range(0, 3))
                0:       v = '0;
                1:       v = '1;
                2:       v = ITEM_W'(MAX_ITEM_BYTES);
                default: v = ITEM_W'(MAX_ITEM_BYTES + 1);
            endcase
        end
        else if (pick <= 5)
        begin
            k    = $urandom_range(1, top_class);
            base = chunk_table[k];
            if (base == 0)
                base = 1;
            v = ITEM_W'(base + $urandom_range(0, 2) - 1);
        end
        else if (pick <= 7)
            v = ITEM_W'($urandom_range(1, 2048));
        else
            v = ITEM_W'($urandom_range(1, MAX_ITEM_BYTES));
        return v;
    endfunction

    // Random factor word; upper bits are junk that the register must drop.
    function automatic logic [DATA_W-1:0] random_factor_word();
        logic [DATA_W-1:0] w;
        int unsigned       pick;
        w    = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            w[FACTOR_W-1:0] = FACTOR_W'($urandom_range(FACTOR_ONE, FACTOR_MAX_GROWTH));
        else if (pick < 9)
            w[FACTOR_W-1:0] = FACTOR_W'($urandom_range(0, FACTOR_ONE - 1));
        return w;
    endfunction

    // Send one request after a random gap (none when no_idle is set) and record its expected result.
    task automatic send_request(input logic [ITEM_W-1:0] bytes);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        item_bytes <= bytes;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_lookups.push_back(lookup_class(bytes));
    endtask

    // Drop valid and wait until every request has produced its result.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge clk);
    endtask

    // APB write; the predictor follows only writes to the factor register.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == FACTOR_ADDR)
        begin
            model_factor = data[FACTOR_W-1:0];
            build_class_table(model_factor);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read of the factor register, compared with the predicted value.
    task automatic check_factor_readback(input logic [FACTOR_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= FACTOR_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== DATA_W'(want))
        begin
            $display("%0t: factor readback expected %0d actual %0d", $time, want, prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_factor(input logic [DATA_W-1:0] data);
        write_reg(FACTOR_ADDR, data);
        check_factor_readback(data[FACTOR_W-1:0]);
    endtask

    // Default table after reset: zero size, boundaries, largest class, oversize.
    task automatic test_reset_table();
        check_factor_readback(FACTOR_RESET);
        send_request('0);
        send_request(ITEM_W'(1));
        send_request(ITEM_W'(chunk_table[1]));
        send_request(ITEM_W'(chunk_table[1] + 1));
        send_request(ITEM_W'(chunk_table[top_class - 1] + 1));
        send_request(ITEM_W'(MAX_ITEM_BYTES));
        send_request(ITEM_W'(MAX_ITEM_BYTES + 1));
        send_request('1);
        wait_idle();
    endtask

    // Factor of exactly one and the steepest nominal growth.
    task automatic test_growth_extremes();
        set_factor(DATA_W'(FACTOR_ONE));
        send_request(ITEM_W'(chunk_table[1]));
        send_request(ITEM_W'(chunk_table[top_class - 1] + 1));
        send_request(ITEM_W'(MAX_ITEM_BYTES));
        wait_idle();
        set_factor(DATA_W'(FACTOR_MAX_GROWTH));
        send_request(ITEM_W'(chunk_table[2]));
        send_request(ITEM_W'(chunk_table[top_class - 1] + 1));
        send_request(ITEM_W'(MAX_ITEM_BYTES));
        wait_idle();
    endtask

    // A zero factor and one below one make the chunk sizes collapse.
    task automatic test_shrinking_factor();
        set_factor('0);
        send_request(ITEM_W'(FIRST_CHUNK_BYTES));
        send_request(ITEM_W'(FIRST_CHUNK_BYTES + 1));
        wait_idle();
        set_factor(DATA_W'(FACTOR_HALF));
        send_request(ITEM_W'(chunk_table[2]));
        send_request(ITEM_W'(FIRST_CHUNK_BYTES + 1));
        wait_idle();
    endtask

    // Oversized write data is masked, and a write to an unused address is ignored.
    task automatic test_register_decode();
        set_factor('1);
        send_request(ITEM_W'(chunk_table[1] + 1));
        wait_idle();
        write_reg(SPARE_ADDR, DATA_W'(FACTOR_RESET));
        check_factor_readback(model_factor);
        send_request(ITEM_W'(chunk_table[top_class - 1]));
        wait_idle();
    endtask

    // Random requests in phases, each with a fresh factor; some phases never idle.
    task automatic test_random_lookups();
        int phase;
        int i;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            no_idle = (phase % 4 == 3);
            set_factor(random_factor_word());
            for (i = 0; i < PHASE_ITEMS; i++)
                send_request(pick_item_bytes());
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stall (none when no_idle is set) before each result, then hold ready until it is taken.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Compare every accepted result with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                $display("%0t: result with no request waiting: class %0d chunk %0d largest %0d",
                         $time, class_id, chunk_bytes, largest_class);
                errors++;
            end
            else
            begin
                next_expected = pending_lookups.pop_front();
                if (class_id !== next_expected.class_id || chunk_bytes !== next_expected.chunk
                    || largest_class !== next_expected.largest)
                begin
                    $display({"%0t: expected class %0d chunk %0d largest %0d, ",
                              "actual class %0d chunk %0d largest %0d"},
                             $time, next_expected.class_id, next_expected.chunk,
                             next_expected.largest, class_id, chunk_bytes, largest_class);
                    errors++;
                end
            end
        end
    end

    // Run limit.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("slab_size_class_lookup_core_test: errors");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        item_bytes = '0;
        errors     = 0;
        no_idle    = 1'b0;
        model_factor = FACTOR_RESET;
        build_class_table(model_factor);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_table();
        test_growth_extremes();
        test_shrinking_factor();
        test_register_decode();
        test_random_lookups();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("slab_size_class_lookup_core_test: clean");
        else
            $display("slab_size_class_lookup_core_test: errors");
        $finish;
    end

endmodule
